/* hdl/sisd_pkg.sv */
package sisd_pkg;

	// Field widths.
	localparam int ValueWidth = 16;
	localparam int PosWidth   = 3;
	localparam int SegWidth   = 8;
	localparam int MagWidth   = 14;
	localparam int DigitWidth = 4;

	// Saturation limits.
	localparam logic signed [ValueWidth-1:0] ValueMax = 16'sd9999;
	localparam logic signed [ValueWidth-1:0] ValueMin = -16'sd999;

	// Reciprocal constants for the constant divisions, each exact over its input range.
	localparam logic [13:0] RecipThousand = 14'd8389;  // (x * 8389) >> 23, x < 10000
	localparam int          ShiftThousand = 23;
	localparam logic [5:0]  RecipHundred  = 6'd41;     // (x * 41) >> 12, x < 1000
	localparam int          ShiftHundred  = 12;
	localparam logic [7:0]  RecipTen      = 8'd205;    // (x * 205) >> 11, x < 100
	localparam int          ShiftTen      = 11;

	// Segment patterns, bit 0 = a ... bit 6 = g, bit 7 = decimal point.
	localparam logic [SegWidth-1:0] SegPoint = 8'h80;
	localparam logic [SegWidth-1:0] SegMinus = 8'h40;
	localparam logic [SegWidth-1:0] SegBlank = 8'h00;

	// Point position codes.
	localparam logic [PosWidth-1:0] PosDigit1 = 3'd1;
	localparam logic [PosWidth-1:0] PosDigit2 = 3'd2;
	localparam logic [PosWidth-1:0] PosDigit3 = 3'd3;
	localparam logic [PosWidth-1:0] PosDigit4 = 3'd4;

	// Control that travels alongside the digits.
	typedef struct packed {
		logic                neg;
		logic [PosWidth-1:0] pos;
		logic                blank;
	} ctl_t;

	function automatic logic [SegWidth-1:0] digit_pattern(input logic [DigitWidth-1:0] d);
		logic [SegWidth-1:0] p;
		unique case (d)
			4'd0: p = 8'h3F;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5B;
			4'd3: p = 8'h4F;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6D;
			4'd6: p = 8'h7D;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7F;
			4'd9: p = 8'h6F;
			default: p = SegBlank;
		endcase
		return p;
	endfunction

endpackage

/* hdl/sisd_front.sv */
// Saturates the input value and splits it into sign and magnitude.
module sisd_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic signed [sisd_pkg::ValueWidth-1:0] value,
	input  logic [sisd_pkg::PosWidth-1:0]         point_position,
	input  logic                                  blank_leading,
	output logic                                  valid_s1,
	output logic [sisd_pkg::MagWidth-1:0]         mag_s1,
	output sisd_pkg::ctl_t                        ctl_s1
);

	logic signed [sisd_pkg::ValueWidth-1:0] sat;
	logic signed [sisd_pkg::ValueWidth-1:0] abs_val;
	logic                                   neg;

	always_comb begin
		if (value > sisd_pkg::ValueMax) begin
			sat = sisd_pkg::ValueMax;
		end else if (value < sisd_pkg::ValueMin) begin
			sat = sisd_pkg::ValueMin;
		end else begin
			sat = value;
		end
		neg     = sat[sisd_pkg::ValueWidth-1];
		abs_val = neg ? -sat : sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1       <= abs_val[sisd_pkg::MagWidth-1:0];
		ctl_s1.neg   <= neg;
		ctl_s1.pos   <= point_position;
		ctl_s1.blank <= blank_leading;
	end

endmodule

/* hdl/sisd_digits.sv */
// Splits a magnitude below 10000 into four decimal digits, one multiplication per stage.
module sisd_digits (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  logic [sisd_pkg::MagWidth-1:0]    mag_s1,
	input  sisd_pkg::ctl_t                   ctl_s1,
	output logic                             valid_s7,
	output logic [3:0][sisd_pkg::DigitWidth-1:0] dig_s7,
	output sisd_pkg::ctl_t                   ctl_s7
);

	logic [5:0] valid_q;

	logic [sisd_pkg::MagWidth-1:0]   mag_s2;
	logic [sisd_pkg::DigitWidth-1:0] d0_s2, d0_s3, d0_s4, d0_s5, d0_s6, d0_s7;
	logic [9:0]                      rem_s3, rem_s4;
	logic [sisd_pkg::DigitWidth-1:0] d1_s4, d1_s5, d1_s6, d1_s7;
	logic [6:0]                      rem_s5, rem_s6;
	logic [sisd_pkg::DigitWidth-1:0] d2_s6, d2_s7;
	logic [sisd_pkg::DigitWidth-1:0] d3_s7;
	sisd_pkg::ctl_t                  ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic [27:0] prod_th;
	logic [15:0] prod_hu;
	logic [14:0] prod_te;
	logic [13:0] th_sub;
	logic [9:0]  hu_sub;
	logic [6:0]  te_sub;

	always_comb begin
		prod_th = 28'(mag_s1) * 28'(sisd_pkg::RecipThousand);
		th_sub  = 14'(d0_s2) * 14'd1000;
		prod_hu = 16'(rem_s3) * 16'(sisd_pkg::RecipHundred);
		hu_sub  = 10'(d1_s4) * 10'd100;
		prod_te = 15'(rem_s5) * 15'(sisd_pkg::RecipTen);
		te_sub  = 7'(d2_s6) * 7'd10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[4:0], valid_s1};
		end
	end

	assign valid_s7 = valid_q[5];

	always_ff @(posedge clk) begin
		// Thousands by reciprocal.
		mag_s2 <= mag_s1;
		d0_s2  <= prod_th[sisd_pkg::ShiftThousand +: sisd_pkg::DigitWidth];
		ctl_s2 <= ctl_s1;
		// Remainder below 1000.
		rem_s3 <= 10'(mag_s2 - th_sub);
		d0_s3  <= d0_s2;
		ctl_s3 <= ctl_s2;
		// Hundreds.
		rem_s4 <= rem_s3;
		d1_s4  <= prod_hu[sisd_pkg::ShiftHundred +: sisd_pkg::DigitWidth];
		d0_s4  <= d0_s3;
		ctl_s4 <= ctl_s3;
		// Remainder below 100.
		rem_s5 <= 7'(rem_s4 - hu_sub);
		d1_s5  <= d1_s4;
		d0_s5  <= d0_s4;
		ctl_s5 <= ctl_s4;
		// Tens.
		rem_s6 <= rem_s5;
		d2_s6  <= prod_te[sisd_pkg::ShiftTen +: sisd_pkg::DigitWidth];
		d1_s6  <= d1_s5;
		d0_s6  <= d0_s5;
		ctl_s6 <= ctl_s5;
		// Units.
		d3_s7  <= 4'(rem_s6 - te_sub);
		d2_s7  <= d2_s6;
		d1_s7  <= d1_s6;
		d0_s7  <= d0_s6;
		ctl_s7 <= ctl_s6;
	end

	assign dig_s7 = {d3_s7, d2_s7, d1_s7, d0_s7};

endmodule

/* hdl/sisd_encode.sv */
// Turns the digits into segment patterns with the sign, blanking and decimal point.
module sisd_encode (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_s7,
	input  logic [3:0][sisd_pkg::DigitWidth-1:0] dig_s7,
	input  sisd_pkg::ctl_t                       ctl_s7,
	output logic                                 valid_s8,
	output logic [3:0][sisd_pkg::SegWidth-1:0]   seg_s8
);

	logic [3:0][sisd_pkg::SegWidth-1:0] seg;
	logic [3:0]                         has_point;
	logic                               bl0, bl1;

	always_comb begin
		has_point[0] = (ctl_s7.pos == sisd_pkg::PosDigit1);
		has_point[1] = (ctl_s7.pos == sisd_pkg::PosDigit2);
		has_point[2] = (ctl_s7.pos == sisd_pkg::PosDigit3);
		has_point[3] = (ctl_s7.pos == sisd_pkg::PosDigit4);

		// The minus sign does not end blanking.
		if (ctl_s7.neg) begin
			seg[0] = sisd_pkg::SegMinus;
			bl0    = ctl_s7.blank;
		end else if (dig_s7[0] == '0 && !has_point[0] && ctl_s7.blank) begin
			seg[0] = sisd_pkg::SegBlank;
			bl0    = 1'b1;
		end else begin
			seg[0] = sisd_pkg::digit_pattern(dig_s7[0]);
			bl0    = 1'b0;
		end

		if (dig_s7[1] == '0 && !has_point[1] && bl0) begin
			seg[1] = sisd_pkg::SegBlank;
			bl1    = 1'b1;
		end else begin
			seg[1] = sisd_pkg::digit_pattern(dig_s7[1]);
			bl1    = 1'b0;
		end

		if (dig_s7[2] == '0 && !has_point[2] && bl1) begin
			seg[2] = sisd_pkg::SegBlank;
		end else begin
			seg[2] = sisd_pkg::digit_pattern(dig_s7[2]);
		end

		// The units digit always shows.
		seg[3] = sisd_pkg::digit_pattern(dig_s7[3]);

		for (int k = 0; k < 4; k++) begin
			if (has_point[k]) begin
				seg[k] = seg[k] | sisd_pkg::SegPoint;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		seg_s8 <= seg;
	end

endmodule

/* hdl/signed_int_to_seven_segment.sv */
// done comes out of the stage-eight register together with the segment outputs.
// Throughput: one transaction per cycle; the eight-stage pipeline takes a new value every cycle.
// busy is held low, since the receiver cannot stall and no stage ever waits.
// Reset: arst_n clears the valid bits of every stage at once, so no stray done appears;
// the data registers carry no reset and are ignored until their valid bit is set.
module signed_int_to_seven_segment (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [sisd_pkg::ValueWidth-1:0] value,
	input  logic [sisd_pkg::PosWidth-1:0]          point_position,
	input  logic                                   blank_leading,
	output logic                                   done,
	output logic [sisd_pkg::SegWidth-1:0]          segments_digit1,
	output logic [sisd_pkg::SegWidth-1:0]          segments_digit2,
	output logic [sisd_pkg::SegWidth-1:0]          segments_digit3,
	output logic [sisd_pkg::SegWidth-1:0]          segments_digit4
);

	// Stage one saturates to -999..9999 and forms sign and magnitude.
	logic                          valid_s1;
	logic [sisd_pkg::MagWidth-1:0] mag_s1;
	sisd_pkg::ctl_t                ctl_s1;

	// Stages two to seven pull out the digits in turn, multiplying by a reciprocal for each
	// digit and then subtracting its weighted value from the remainder, which leaves the units.
	logic                                 valid_s7;
	logic [3:0][sisd_pkg::DigitWidth-1:0] dig_s7;
	sisd_pkg::ctl_t                       ctl_s7;

	// Stage eight applies the sign, leading-zero blanking and the decimal point.
	logic                               valid_s8;
	logic [3:0][sisd_pkg::SegWidth-1:0] seg_s8;

	// Every stage moves on every cycle, so a transaction is taken whenever start is high.
	assign busy = 1'b0;

	sisd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start && !busy),
		.value          (value),
		.point_position (point_position),
		.blank_leading  (blank_leading),
		.valid_s1       (valid_s1),
		.mag_s1         (mag_s1),
		.ctl_s1         (ctl_s1)
	);

	sisd_digits u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.mag_s1   (mag_s1),
		.ctl_s1   (ctl_s1),
		.valid_s7 (valid_s7),
		.dig_s7   (dig_s7),
		.ctl_s7   (ctl_s7)
	);

	sisd_encode u_encode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s7 (valid_s7),
		.dig_s7   (dig_s7),
		.ctl_s7   (ctl_s7),
		.valid_s8 (valid_s8),
		.seg_s8   (seg_s8)
	);

	// The result stands for exactly one cycle, marked by done.
	assign done            = valid_s8;
	assign segments_digit1 = seg_s8[0];
	assign segments_digit2 = seg_s8[1];
	assign segments_digit3 = seg_s8[2];
	assign segments_digit4 = seg_s8[3];

endmodule

/* tb/sv/seven_segment_checker.sv */
module seven_segment_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic signed [sisd_pkg::ValueWidth-1:0] value,
	input  logic [sisd_pkg::PosWidth-1:0]          point_position,
	input  logic                                   blank_leading,
	input  logic                                   done,
	input  logic [sisd_pkg::SegWidth-1:0]          segments_digit1,
	input  logic [sisd_pkg::SegWidth-1:0]          segments_digit2,
	input  logic [sisd_pkg::SegWidth-1:0]          segments_digit3,
	input  logic [sisd_pkg::SegWidth-1:0]          segments_digit4,
	output int unsigned                            fail_count,
	output int unsigned                            pending,
	output int unsigned                            checked
);

	localparam int ReportLimit = 10;

	localparam logic [sisd_pkg::SegWidth-1:0] DigitSegments [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	localparam logic [sisd_pkg::PosWidth-1:0] PointCode [4] = '{
		sisd_pkg::PosDigit1, sisd_pkg::PosDigit2, sisd_pkg::PosDigit3, sisd_pkg::PosDigit4
	};

	typedef logic [3:0][sisd_pkg::SegWidth-1:0] display_t;

	display_t    display_q [$];
	int unsigned reported;

	// Index 0 is the leftmost digit.
	function automatic display_t predict_display(
		input logic signed [sisd_pkg::ValueWidth-1:0] raw,
		input logic [sisd_pkg::PosWidth-1:0] pos, input logic blank);
		int       num;
		int       mag;
		int       digit [4];
		int       first;
		int       k;
		logic     blanking;
		display_t seg;
		num = raw;
		if (num > sisd_pkg::ValueMax) begin
			num = sisd_pkg::ValueMax;
		end
		if (num < sisd_pkg::ValueMin) begin
			num = sisd_pkg::ValueMin;
		end
		mag = (num < 0) ? -num : num;
		digit[0] = mag / 1000;
		digit[1] = (mag / 100) % 10;
		digit[2] = (mag / 10) % 10;
		digit[3] = mag % 10;
		seg = '0;
		first = 0;
		if (num < 0) begin
			seg[0] = sisd_pkg::SegMinus;
			first = 1;
		end
		// The minus sign never ends blanking; a nonzero digit or the point digit does.
		blanking = blank;
		for (k = first; k < 3; k++) begin
			if (digit[k] == 0 && pos != PointCode[k] && blanking) begin
				seg[k] = sisd_pkg::SegBlank;
			end else begin
				seg[k] = DigitSegments[digit[k]];
				blanking = 1'b0;
			end
		end
		seg[3] = DigitSegments[digit[3]];
		for (k = 0; k < 4; k++) begin
			if (pos == PointCode[k]) begin
				seg[k] = seg[k] | sisd_pkg::SegPoint;
			end
		end
		return seg;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		display_t got;
		display_t want;
		int       k;
		if (!arst_n) begin
			display_q.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			reported    = 0;
		end else begin
			if (start && !busy) begin
				display_q.push_back(predict_display(value, point_position, blank_leading));
			end
			if (done) begin
				got = {segments_digit4, segments_digit3, segments_digit2, segments_digit1};
				if (display_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (reported < ReportLimit) begin
						$display("ERROR: result %h %h %h %h with no transaction outstanding",
							got[0], got[1], got[2], got[3]);
					end
					reported++;
				end else begin
					want = display_q.pop_front();
					checked <= checked + 1;
					if (got != want) begin
						fail_count <= fail_count + 1;
						for (k = 0; k < 4; k++) begin
							if (got[k] != want[k] && reported < ReportLimit) begin
								$display("ERROR: segments_digit%0d expected %h, got %h",
									k + 1, want[k], got[k]);
							end
						end
						reported++;
					end
				end
			end
			pending <= display_q.size();
		end
	end

endmodule

/* tb/sv/signed_int_to_seven_segment_test.sv */
module signed_int_to_seven_segment_test;

	// The watchdog trips after this many cycles in which no transaction is accepted
	// and no result appears. The longest quiet stretch of a correct run is the final
	// wait for the last result followed by the closing drain cycles, so this is ample.
	localparam int StallLimit   = 1000;
	localparam int RandomItems  = 1050;
	// The last part of the run drives back-to-back transactions with no idling.
	localparam int QuietTail    = 150;
	localparam int PressureItem = 500;
	localparam int DrainCycles  = 16;

	logic                                   clk = 1'b0;
	logic                                   arst_n;
	logic                                   start;
	logic                                   busy;
	logic signed [sisd_pkg::ValueWidth-1:0] value;
	logic [sisd_pkg::PosWidth-1:0]          point_position;
	logic                                   blank_leading;
	logic                                   done;
	logic [sisd_pkg::SegWidth-1:0]          segments_digit1;
	logic [sisd_pkg::SegWidth-1:0]          segments_digit2;
	logic [sisd_pkg::SegWidth-1:0]          segments_digit3;
	logic [sisd_pkg::SegWidth-1:0]          segments_digit4;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned items_sent;
	int unsigned stall_cycles = 0;

	// Period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	signed_int_to_seven_segment u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.point_position  (point_position),
		.blank_leading   (blank_leading),
		.done            (done),
		.segments_digit1 (segments_digit1),
		.segments_digit2 (segments_digit2),
		.segments_digit3 (segments_digit3),
		.segments_digit4 (segments_digit4)
	);

	// The checker sits beside the block, predicts every accepted transaction and
	// compares each result as it appears; it only reports counts back to this module.
	seven_segment_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.point_position  (point_position),
		.blank_leading   (blank_leading),
		.done            (done),
		.segments_digit1 (segments_digit1),
		.segments_digit2 (segments_digit2),
		.segments_digit3 (segments_digit3),
		.segments_digit4 (segments_digit4),
		.fail_count      (fail_count),
		.pending         (pending),
		.checked         (checked)
	);

	// Watchdog. Signals are read at the edge before the nonblocking updates land, so
	// this sees the same handshake values as the block itself.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= StallLimit) begin
			$display("Watchdog: no transaction for %0d cycles", StallLimit);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Presents one transaction and holds it until the block accepts it. busy is looked at
	// on the falling edge, where it is stable, to decide whether the coming rising edge
	// accepts. start is left high on return, so a following transaction goes out
	// back to back without start dropping in between.
	task automatic send_transaction(input logic signed [sisd_pkg::ValueWidth-1:0] v,
		input logic [sisd_pkg::PosWidth-1:0] p, input logic b);
		logic ready;
		start          <= 1'b1;
		value          <= v;
		point_position <= p;
		blank_leading  <= b;
		ready = 1'b0;
		while (!ready) begin
			@(negedge clk);
			ready = !busy;
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Drops start for the given number of cycles and scribbles on the payload, which must be ignored.
	task automatic hold_off(input int cycles);
		start          <= 1'b0;
		value          <= sisd_pkg::ValueWidth'($urandom);
		point_position <= sisd_pkg::PosWidth'($urandom);
		blank_leading  <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Waits until the checker has seen a result for every accepted transaction. The first
	// edge is taken unconditionally so that the count already includes the last push.
	task automatic wait_for_drain();
		do begin
			@(posedge clk);
		end while (pending != 0);
	endtask

	// Random value, weighted towards small magnitudes where blanking has most to do,
	// with a share across the whole sixteen-bit range to exercise saturation.
	function automatic logic signed [sisd_pkg::ValueWidth-1:0] pick_value();
		int sel;
		int num;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2: begin
				num = int'($urandom_range(0, 198)) - 99;
			end
			3, 4, 5: begin
				num = int'($urandom_range(0, 10998)) - 999;
			end
			6: begin
				num = int'($urandom_range(0, 9)) * (10 ** int'($urandom_range(0, 3)));
				if ($urandom_range(0, 1) == 1) begin
					num = -num;
				end
			end
			7: begin
				num = ($urandom_range(0, 1) == 1) ? int'($urandom_range(9990, 10010))
					: -int'($urandom_range(990, 1010));
			end
			default: begin
				num = int'($signed(sisd_pkg::ValueWidth'($urandom)));
			end
		endcase
		return sisd_pkg::ValueWidth'(num);
	endfunction

	// Mostly a real digit position or none, now and then one of the unused codes.
	function automatic logic [sisd_pkg::PosWidth-1:0] pick_point();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 4) begin
			return sisd_pkg::PosWidth'(sel);
		end
		return sisd_pkg::PosWidth'($urandom_range(0, 7));
	endfunction

	initial begin
		int i;
		arst_n         = 1'b0;
		start          = 1'b0;
		value          = '0;
		point_position = '0;
		blank_leading  = 1'b0;
		items_sent     = 0;

		// Reset is applied once and released on a rising edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: range extremes, saturation on both sides, all point codes,
		// the minus sign not ending blanking, and a point landing on a blanked zero.
		send_transaction(16'sd0, 3'd0, 1'b1);
		send_transaction(16'sd0, 3'd0, 1'b0);
		send_transaction(sisd_pkg::ValueMax, 3'd0, 1'b1);
		send_transaction(16'sd10000, sisd_pkg::PosDigit2, 1'b1);
		send_transaction(16'sh7FFF, 3'd7, 1'b0);
		send_transaction(16'sh8000, 3'd5, 1'b1);
		send_transaction(sisd_pkg::ValueMin, sisd_pkg::PosDigit1, 1'b1);
		send_transaction(-16'sd1000, 3'd6, 1'b0);
		send_transaction(-16'sd5, 3'd0, 1'b1);
		send_transaction(-16'sd5, 3'd0, 1'b0);
		send_transaction(-16'sd5, sisd_pkg::PosDigit2, 1'b1);
		send_transaction(16'sd5, sisd_pkg::PosDigit3, 1'b1);
		send_transaction(16'sd5, sisd_pkg::PosDigit1, 1'b1);
		send_transaction(16'sd1000, sisd_pkg::PosDigit4, 1'b1);
		hold_off(5);
		send_transaction(16'sd100, 3'd0, 1'b1);
		send_transaction(16'sd10, sisd_pkg::PosDigit2, 1'b1);
		send_transaction(-16'sd1, sisd_pkg::PosDigit1, 1'b1);
		send_transaction(-16'sd50, sisd_pkg::PosDigit3, 1'b1);
		send_transaction(16'sd1234, sisd_pkg::PosDigit4, 1'b0);
		send_transaction(16'sd5678, sisd_pkg::PosDigit2, 1'b1);
		send_transaction(16'sd9, 3'd0, 1'b0);
		send_transaction(-16'sd909, sisd_pkg::PosDigit4, 1'b1);
		send_transaction(16'sd0, sisd_pkg::PosDigit1, 1'b1);

		// Random part with idle bursts; once in the middle the sender waits until every
		// outstanding result has come back, and the final stretch runs flat out.
		for (i = 0; i < RandomItems; i++) begin
			if (i == PressureItem) begin
				start <= 1'b0;
				wait_for_drain();
			end else if (i < RandomItems - QuietTail && $urandom_range(0, 5) == 0) begin
				hold_off($urandom_range(1, 11));
			end
			send_transaction(pick_value(), pick_point(), 1'($urandom));
		end
		start <= 1'b0;

		wait_for_drain();
		repeat (DrainCycles) @(posedge clk);

		$display("Summary: %0d transactions sent, %0d results checked.", items_sent, checked);
		$display("Covered saturation both ways, sign, blanking and every point code.");
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d failures, %0d results missing", fail_count, pending);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/sisd_pkg.sv
hdl/sisd_front.sv
hdl/sisd_digits.sv
hdl/sisd_encode.sv
hdl/signed_int_to_seven_segment.sv
tb/sv/seven_segment_checker.sv
tb/sv/signed_int_to_seven_segment_test.sv
